### hdl/frc_pkg.sv
// ============================================================================
// frc_pkg: shared types and constants for fragment reassembly control
// Action and sequence status codes, flag bit positions and the decision
// record that passes from the decision logic to the top level.
// ============================================================================
package frc_pkg;

    localparam int FlagBBit = 2;
    localparam int FlagEBit = 1;
    localparam int FlagIBit = 0;

    localparam int FlagsW   = 4;
    localparam int TicksW   = 64;
    localparam int IngressW = 32;
    localparam int SeqInW   = 20;

    typedef enum logic [2:0] {
        ACT_PASS          = 3'd0,
        ACT_IDLE          = 3'd1,
        ACT_BAD           = 3'd2,
        ACT_BEGIN         = 3'd3,
        ACT_BEGIN_DELIVER = 3'd4,
        ACT_CONTINUE      = 3'd5,
        ACT_END_DELIVER   = 3'd6,
        ACT_ABORT         = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        ST_IN_ORDER = 2'd0,
        ST_OLDER    = 2'd1,
        ST_AHEAD    = 2'd2
    } seq_status_t;

    typedef struct packed {
        action_t                action;
        seq_status_t            seq_status;
        logic                   partial_dropped;
        logic [TicksW-1:0]      deliver_ticks;
        logic [IngressW-1:0]    deliver_ingress;
        logic                   assembling_next;
        logic                   store_first;
        logic                   update_seq;
    } frc_decision_t;

endpackage

### hdl/frc_decide.sv
// ============================================================================
// frc_decide: per-item reassembly decision
// Compares the sequence number with the expected one and walks the idle and
// busy rules for one registered header, producing the result and next state.
// ============================================================================
module frc_decide #(
    parameter int SEQ_BITS = 20
) (
    input  logic                                is_fragment,
    input  logic [frc_pkg::FlagsW-1:0]          frag_flags,
    input  logic [frc_pkg::SeqInW-1:0]          seq_number,
    input  logic [frc_pkg::TicksW-1:0]          arrival_ticks,
    input  logic [frc_pkg::IngressW-1:0]        ingress_port,
    input  logic [SEQ_BITS-1:0]                 expected_seq,
    input  logic                                assembling,
    input  logic [frc_pkg::TicksW-1:0]          first_ticks,
    input  logic [frc_pkg::IngressW-1:0]        first_ingress,
    output logic [SEQ_BITS-1:0]                 expected_next,
    output frc_pkg::frc_decision_t              decision
);
    import frc_pkg::*;

    logic [SEQ_BITS-1:0] seq_w;
    logic [SEQ_BITS-1:0] seq_diff;
    seq_status_t         status;
    logic                busy;

    assign seq_w         = SEQ_BITS'(seq_number);
    assign seq_diff      = seq_w - expected_seq;
    assign expected_next = seq_w + SEQ_BITS'(1);

    always_comb begin
        if (seq_diff == '0) begin
            status = ST_IN_ORDER;
        end else if (seq_diff[SEQ_BITS-1]) begin
            status = ST_OLDER;
        end else begin
            status = ST_AHEAD;
        end
    end

    assign busy = assembling && (status == ST_IN_ORDER);

    always_comb begin
        decision                 = '0;
        decision.action          = ACT_PASS;
        decision.seq_status      = ST_IN_ORDER;
        decision.assembling_next = assembling;
        if (is_fragment) begin
            decision.seq_status      = status;
            decision.update_seq      = 1'b1;
            decision.partial_dropped = assembling && (status != ST_IN_ORDER);
            if (!busy) begin
                decision.assembling_next = 1'b0;
                priority if (frag_flags[FlagBBit]) begin
                    decision.store_first = 1'b1;
                    if (frag_flags[FlagEBit]) begin
                        decision.action          = ACT_BEGIN_DELIVER;
                        decision.deliver_ticks   = arrival_ticks;
                        decision.deliver_ingress = ingress_port;
                    end else begin
                        decision.action          = ACT_BEGIN;
                        decision.assembling_next = 1'b1;
                    end
                end else if (frag_flags[FlagIBit]) begin
                    decision.action = ACT_IDLE;
                end else begin
                    decision.action = ACT_BAD;
                end
            end else begin
                priority if (frag_flags == '0) begin
                    decision.action = ACT_CONTINUE;
                end else if (frag_flags[FlagEBit]) begin
                    decision.action          = ACT_END_DELIVER;
                    decision.deliver_ticks   = first_ticks;
                    decision.deliver_ingress = first_ingress;
                    decision.assembling_next = 1'b0;
                end else begin
                    decision.action          = ACT_ABORT;
                    decision.partial_dropped = 1'b1;
                    decision.assembling_next = 1'b0;
                end
            end
        end
    end

endmodule

### hdl/fragment_reassembly_control_core.sv
// ============================================================================
// fragment_reassembly_control_core: hop-by-hop fragment reassembly control
// Path: an accepted input item is held in the input register, its result
// then in the result register. Throughput: one item per cycle while m_tready
// does not stall, set by the single decision stage between the two registers.
// Reset: aresetn low empties both registers and returns to idle with the
// expected sequence number at zero.
// ============================================================================
module fragment_reassembly_control_core #(
    parameter int SEQ_BITS = 20
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata fields from bit 0: seq_number, arrival_ticks, ingress_port.
    input  logic [119:0] s_tdata,
    // tuser fields from bit 0: is_fragment, frag_flags.
    input  logic [4:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata fields from bit 0: seq_status, partial_dropped, deliver_ticks,
    // deliver_ingress.
    output logic [103:0] m_tdata,
    // tuser fields from bit 0: action.
    output logic [2:0]   m_tuser
);
    import frc_pkg::*;

    logic                  in_valid_reg;
    logic [119:0]          in_data_reg;
    logic [4:0]            in_user_reg;
    logic                  advance;

    logic [SEQ_BITS-1:0]   expected_seq_reg;
    logic [SEQ_BITS-1:0]   expected_seq_next;
    logic                  assembling_reg;
    logic [TicksW-1:0]     first_ticks_reg;
    logic [IngressW-1:0]   first_ingress_reg;

    frc_decision_t         decision;
    logic                  out_valid_reg;
    frc_decision_t         out_reg;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_user_reg <= s_tuser;
        end
    end

    frc_decide #(
        .SEQ_BITS(SEQ_BITS)
    ) u_decide (
        .is_fragment   (in_user_reg[0]),
        .frag_flags    (in_user_reg[4:1]),
        .seq_number    (in_data_reg[19:0]),
        .arrival_ticks (in_data_reg[83:20]),
        .ingress_port  (in_data_reg[115:84]),
        .expected_seq  (expected_seq_reg),
        .assembling    (assembling_reg),
        .first_ticks   (first_ticks_reg),
        .first_ingress (first_ingress_reg),
        .expected_next (expected_seq_next),
        .decision      (decision)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_seq_reg <= '0;
            assembling_reg   <= 1'b0;
        end else if (advance) begin
            assembling_reg <= decision.assembling_next;
            if (decision.update_seq) begin
                expected_seq_reg <= expected_seq_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && decision.store_first) begin
            first_ticks_reg   <= in_data_reg[83:20];
            first_ingress_reg <= in_data_reg[115:84];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= decision;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.action;
    assign m_tdata  = {5'd0, out_reg.deliver_ingress, out_reg.deliver_ticks,
                       out_reg.partial_dropped, out_reg.seq_status};

    a_deliver_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.action != ACT_BEGIN_DELIVER
            && out_reg.action != ACT_END_DELIVER
        |-> out_reg.deliver_ticks == '0 && out_reg.deliver_ingress == '0)
        else $error("deliver fields set on a non-deliver action");

    a_pass_clean : assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.action == ACT_PASS
        |-> out_reg.seq_status == ST_IN_ORDER && !out_reg.partial_dropped)
        else $error("pass-through item carries sequence status or drop");

    a_seq_resync : assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_user_reg[0]
        |=> expected_seq_reg == $past(expected_seq_next))
        else $error("expected sequence number did not resync");

    a_nonfrag_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !in_user_reg[0]
        |=> assembling_reg == $past(assembling_reg)
            && expected_seq_reg == $past(expected_seq_reg))
        else $error("non-fragment item changed reassembly state");

endmodule
